// ----- rtl/core/sls_pkg.sv -----
package sls_pkg;

	typedef logic [8:0]  angle_t;
	typedef logic [2:0]  mode_t;
	typedef logic [3:0]  pos_t;
	typedef logic [4:0]  len_t;
	typedef logic [31:0] usec_t;

	localparam angle_t ANGLE_MAX = 9'd360;

	localparam mode_t M_RESET    = 3'd0;
	localparam mode_t M_IDLE     = 3'd1;
	localparam mode_t M_ASSEMBLY = 3'd2;
	localparam mode_t M_INC      = 3'd3;
	localparam mode_t M_DEC      = 3'd4;
	localparam mode_t M_SHOOT    = 3'd5;
	localparam mode_t M_DECAY    = 3'd6;
	localparam mode_t M_REARM    = 3'd7;

	localparam logic [2:0] BTN_INC    = 3'd0;
	localparam logic [2:0] BTN_DEC    = 3'd1;
	localparam logic [2:0] BTN_SHOOT  = 3'd2;
	localparam logic [2:0] BTN_CONFIG = 3'd3;
	localparam logic [2:0] BTN_NORMAL = 3'd4;

	localparam logic OP_STEP  = 1'b0;
	localparam logic OP_TABLE = 1'b1;

	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_LOCK_CLOSED = 3'd0;
	localparam reg_idx_t REG_LOCK_OPEN   = 3'd1;
	localparam reg_idx_t REG_WIND_HOME   = 3'd2;
	localparam reg_idx_t REG_LASER_ASM   = 3'd3;
	localparam reg_idx_t REG_TIMEOUT     = 3'd4;
	localparam reg_idx_t REG_POSITIONS   = 3'd5;

	typedef struct packed {
		angle_t lock_closed;
		angle_t lock_open;
		angle_t wind_home;
		angle_t laser_asm;
		usec_t  timeout;
		len_t   positions_used;
	} cfg_t;

	typedef struct packed {
		logic       op;
		logic [2:0] button;
		logic       pressed;
		usec_t      now_time;
		pos_t       entry_index;
		angle_t     entry_laser;
		angle_t     entry_wind;
	} item_t;

	typedef struct packed {
		mode_t  mode;
		pos_t   pos;
		angle_t lock;
		angle_t wind;
		angle_t laser;
		usec_t  shot;
	} st_t;

	function automatic angle_t clamp_angle(input angle_t v);
		return (v > ANGLE_MAX) ? ANGLE_MAX : v;
	endfunction

endpackage

// ----- rtl/core/sls_if.sv -----
interface sls_step_if;
	import sls_pkg::*;

	logic       valid;
	logic       ready;
	logic       op;
	logic [2:0] button;
	logic       pressed;
	usec_t      now_time;
	pos_t       entry_index;
	angle_t     entry_laser;
	angle_t     entry_wind;

	modport source (output valid, op, button, pressed, now_time, entry_index, entry_laser,
		entry_wind, input ready);
	modport sink (input valid, op, button, pressed, now_time, entry_index, entry_laser,
		entry_wind, output ready);
endinterface

interface sls_result_if;
	import sls_pkg::*;

	logic   valid;
	logic   ready;
	mode_t  mode_code;
	pos_t   position;
	angle_t lock_out;
	angle_t wind_out;
	angle_t laser_out;

	modport source (output valid, mode_code, position, lock_out, wind_out, laser_out,
		input ready);
	modport sink (input valid, mode_code, position, lock_out, wind_out, laser_out,
		output ready);
endinterface

interface sls_cfg_if;
	import sls_pkg::*;

	logic        valid;
	logic        ready;
	reg_idx_t    index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/sls_ram.sv -----
module sls_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ----- rtl/core/sls_ctrl.sv -----
module sls_ctrl (
	input  sls_pkg::st_t   st,
	input  sls_pkg::cfg_t  cfg,
	input  sls_pkg::item_t it,
	input  sls_pkg::len_t  len,
	output sls_pkg::st_t   nxt,
	output logic           ld
);
	import sls_pkg::*;

	pos_t   dec_pos;
	angle_t wind_inc;
	usec_t  elapsed;

	always_comb begin
		dec_pos  = st.pos - 4'd1;
		wind_inc = (st.wind < ANGLE_MAX) ? st.wind + 9'd1 : st.wind;
		elapsed  = it.now_time - st.shot;
		nxt      = st;
		ld       = 1'b0;
		if (it.op == OP_STEP) begin
			unique case (st.mode)
				M_RESET: begin
					nxt.lock = cfg.lock_closed;
					if (len != 5'd0) begin
						nxt.pos = 4'd0;
						ld      = 1'b1;
					end
					nxt.mode = M_IDLE;
				end
				M_IDLE: begin
					priority if (it.pressed && it.button == BTN_INC) begin
						if (len != 5'd0 && ({1'b0, st.pos} + 5'd1) < len) begin
							nxt.pos = st.pos + 4'd1;
							ld      = 1'b1;
						end
						nxt.mode = M_INC;
					end else if (it.pressed && it.button == BTN_DEC) begin
						if (len != 5'd0 && st.pos != 4'd0) begin
							nxt.pos = dec_pos;
							ld      = ({1'b0, dec_pos} < len);
						end
						nxt.mode = M_DEC;
					end else if (it.pressed && it.button == BTN_SHOOT) begin
						nxt.mode = M_SHOOT;
					end else if (it.pressed && it.button == BTN_CONFIG) begin
						nxt.mode = M_ASSEMBLY;
					end else begin
						nxt.mode = M_IDLE;
					end
				end
				M_ASSEMBLY: begin
					if (it.pressed && it.button == BTN_NORMAL) begin
						nxt.mode = M_RESET;
					end
					nxt.lock  = cfg.lock_open;
					nxt.wind  = cfg.wind_home;
					nxt.laser = cfg.laser_asm;
				end
				M_INC: begin
					if (!it.pressed && it.button == BTN_INC) begin
						nxt.mode = M_IDLE;
					end
				end
				M_DEC: begin
					if (!it.pressed && it.button == BTN_DEC) begin
						nxt.mode = M_IDLE;
					end
				end
				M_SHOOT: begin
					nxt.lock = cfg.lock_open;
					nxt.shot = it.now_time;
					nxt.mode = M_DECAY;
				end
				M_DECAY: begin
					nxt.wind = wind_inc;
					if (wind_inc >= cfg.wind_home) begin
						nxt.mode = M_REARM;
					end
				end
				M_REARM: begin
					if (elapsed > cfg.timeout) begin
						nxt.mode = M_RESET;
					end
				end
			endcase
		end
	end
endmodule

// ----- rtl/core/servo_launch_sequencer.sv -----
// Launcher sequencer: one result beat per step beat, in order. A beat is taken
// into an input register and its mode, index and angle update is worked out
// into the state registers, which drive the result port; one beat is accepted
// every cycle while results are taken, and one more beat is absorbed while a
// result waits. Table-write beats fill one angle RAM of TABLE_DEPTH entries
// (laser and wind side by side); a beat that sets a new index inside the used
// length reads that RAM, and its wind and laser angles come from the registered
// read data until the next beat is processed. Configuration writes are taken at
// any time and must be issued only while the block is idle.
module servo_launch_sequencer #(
	parameter int TABLE_DEPTH = 16
) (
	input logic         clk,
	input logic         arst_n,
	sls_step_if.sink    step,
	sls_result_if.source result,
	sls_cfg_if.sink     cfg
);
	import sls_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	cfg_t   cfg_q;
	len_t   len;
	logic   valid_s1;
	item_t  item_s1;
	logic   adv;
	logic   out_valid_q;
	mode_t  mode_q;
	pos_t   pos_q;
	angle_t lock_q;
	angle_t wind_q;
	angle_t laser_q;
	usec_t  shot_q;
	logic   pend_q;
	st_t    cur;
	st_t    nxt;
	logic   ld;
	logic   tbl_we;
	logic [17:0] rdata;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lock_closed    <= 9'd0;
			cfg_q.lock_open      <= 9'd180;
			cfg_q.wind_home      <= 9'd180;
			cfg_q.laser_asm      <= 9'd180;
			cfg_q.timeout        <= 32'd1000000;
			cfg_q.positions_used <= 5'd16;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_LOCK_CLOSED: cfg_q.lock_closed    <= clamp_angle(cfg.data[8:0]);
				REG_LOCK_OPEN:   cfg_q.lock_open      <= clamp_angle(cfg.data[8:0]);
				REG_WIND_HOME:   cfg_q.wind_home      <= clamp_angle(cfg.data[8:0]);
				REG_LASER_ASM:   cfg_q.laser_asm      <= clamp_angle(cfg.data[8:0]);
				REG_TIMEOUT:     cfg_q.timeout        <= cfg.data;
				REG_POSITIONS:   cfg_q.positions_used <= cfg.data[4:0];
				default: ;
			endcase
		end
	end

	assign len = (32'(cfg_q.positions_used) > TABLE_DEPTH) ? 5'(TABLE_DEPTH)
		: cfg_q.positions_used;

	// input register
	assign adv        = valid_s1 && (!out_valid_q || result.ready);
	assign step.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (step.valid && step.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step.valid && step.ready) begin
			item_s1.op          <= step.op;
			item_s1.button      <= step.button;
			item_s1.pressed     <= step.pressed;
			item_s1.now_time    <= step.now_time;
			item_s1.entry_index <= step.entry_index;
			item_s1.entry_laser <= step.entry_laser;
			item_s1.entry_wind  <= step.entry_wind;
		end
	end

	// angles come from the RAM read data after a beat that read the table
	always_comb begin
		cur.mode  = mode_q;
		cur.pos   = pos_q;
		cur.lock  = lock_q;
		cur.wind  = pend_q ? rdata[8:0] : wind_q;
		cur.laser = pend_q ? rdata[17:9] : laser_q;
		cur.shot  = shot_q;
	end

	sls_ctrl u_ctrl (
		.st  (cur),
		.cfg (cfg_q),
		.it  (item_s1),
		.len (len),
		.nxt (nxt),
		.ld  (ld)
	);

	assign tbl_we = adv && item_s1.op == OP_TABLE && 32'(item_s1.entry_index) < TABLE_DEPTH;

	sls_ram #(
		.WIDTH (18),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (AW'(item_s1.entry_index)),
		.wdata ({clamp_angle(item_s1.entry_laser), clamp_angle(item_s1.entry_wind)}),
		.re    (adv && ld),
		.raddr (AW'(nxt.pos)),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= M_RESET;
			pos_q       <= 4'd0;
			lock_q      <= 9'd0;
			wind_q      <= 9'd0;
			laser_q     <= 9'd0;
			shot_q      <= 32'd0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			mode_q      <= nxt.mode;
			pos_q       <= nxt.pos;
			lock_q      <= nxt.lock;
			wind_q      <= nxt.wind;
			laser_q     <= nxt.laser;
			shot_q      <= nxt.shot;
			pend_q      <= ld;
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.mode_code = mode_q;
	assign result.position  = pos_q;
	assign result.lock_out  = lock_q;
	assign result.wind_out  = cur.wind;
	assign result.laser_out = cur.laser;

`ifndef SYNTHESIS
	a_hold_state: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(mode_q) && $stable(pos_q) && $stable(shot_q) && $stable(pend_q))
		else $error("state moved without a beat");

	a_load_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		adv && ld |=> pend_q && ({1'b0, pos_q} < $past(len)))
		else $error("table read outside the used length");

	a_rearm_exit: assert property (@(posedge clk) disable iff (!arst_n)
		adv && mode_q == M_REARM |=> mode_q == M_REARM || mode_q == M_RESET)
		else $error("rearm wait left to a mode other than reset");
`endif
endmodule

// ----- dv/tb_servo_launch_sequencer.sv -----
module tb_servo_launch_sequencer;
	import sls_pkg::*;

	localparam int DEPTH = 16;
	localparam logic [2:0] BTN_SPARE_LO = 3'd5;
	localparam logic [2:0] BTN_SPARE_HI = 3'd7;

	typedef struct packed {
		mode_t  mode;
		pos_t   pos;
		angle_t lock;
		angle_t wind;
		angle_t laser;
	} pose_t;

	logic clk;
	logic arst_n;

	sls_step_if   step_bus();
	sls_result_if pose_bus();
	sls_cfg_if    cfg_bus();

	servo_launch_sequencer uut (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (step_bus),
		.result(pose_bus),
		.cfg   (cfg_bus)
	);

	cfg_t   cfg_sh;
	mode_t  sh_mode;
	pos_t   sh_pos;
	angle_t sh_lock;
	angle_t sh_wind;
	angle_t sh_laser;
	usec_t  sh_shot;
	angle_t laser_tab [DEPTH];
	angle_t wind_tab [DEPTH];

	pose_t  pose_due [$];
	int     mismatches;
	int     idle_pct;
	usec_t  usec_clock;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	initial begin
		#10_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic angle_t sat_angle(input angle_t v);
		return (v > ANGLE_MAX) ? ANGLE_MAX : v;
	endfunction

	function automatic int table_len();
		return (cfg_sh.positions_used > 5'(DEPTH)) ? DEPTH : int'(cfg_sh.positions_used);
	endfunction

	function automatic void fetch_angles();
		if (int'(sh_pos) < table_len()) begin
			sh_laser = laser_tab[sh_pos];
			sh_wind  = wind_tab[sh_pos];
		end
	endfunction

	function automatic pose_t advance_sequencer(input item_t it);
		int len;
		len = table_len();
		if (it.op == OP_TABLE) begin
			laser_tab[it.entry_index] = sat_angle(it.entry_laser);
			wind_tab[it.entry_index]  = sat_angle(it.entry_wind);
		end else begin
			case (sh_mode)
			M_RESET: begin
				sh_lock = cfg_sh.lock_closed;
				if (len > 0) begin
					sh_pos = '0;
					fetch_angles();
				end
				sh_mode = M_IDLE;
			end
			M_IDLE: begin
				if (it.pressed && it.button == BTN_INC) begin
					if (len > 0 && int'(sh_pos) < len - 1) begin
						sh_pos = sh_pos + 1'b1;
						fetch_angles();
					end
					sh_mode = M_INC;
				end else if (it.pressed && it.button == BTN_DEC) begin
					if (len > 0 && sh_pos != '0) begin
						sh_pos = sh_pos - 1'b1;
						fetch_angles();
					end
					sh_mode = M_DEC;
				end else if (it.pressed && it.button == BTN_SHOOT) begin
					sh_mode = M_SHOOT;
				end else if (it.pressed && it.button == BTN_CONFIG) begin
					sh_mode = M_ASSEMBLY;
				end
			end
			M_ASSEMBLY: begin
				if (it.pressed && it.button == BTN_NORMAL)
					sh_mode = M_RESET;
				sh_lock  = cfg_sh.lock_open;
				sh_wind  = cfg_sh.wind_home;
				sh_laser = cfg_sh.laser_asm;
			end
			M_INC: begin
				if (!it.pressed && it.button == BTN_INC)
					sh_mode = M_IDLE;
			end
			M_DEC: begin
				if (!it.pressed && it.button == BTN_DEC)
					sh_mode = M_IDLE;
			end
			M_SHOOT: begin
				sh_lock = cfg_sh.lock_open;
				sh_shot = it.now_time;
				sh_mode = M_DECAY;
			end
			M_DECAY: begin
				if (sh_wind < ANGLE_MAX)
					sh_wind = sh_wind + 1'b1;
				if (sh_wind >= cfg_sh.wind_home)
					sh_mode = M_REARM;
			end
			default: begin
				if (usec_t'(it.now_time - sh_shot) > cfg_sh.timeout)
					sh_mode = M_RESET;
			end
			endcase
		end
		return '{sh_mode, sh_pos, sh_lock, sh_wind, sh_laser};
	endfunction

	function automatic item_t step_item(input logic [2:0] b, input logic p, input usec_t t);
		item_t it;
		it.op          = OP_STEP;
		it.button      = b;
		it.pressed     = p;
		it.now_time    = t;
		it.entry_index = 4'($urandom);
		it.entry_laser = 9'($urandom);
		it.entry_wind  = 9'($urandom);
		return it;
	endfunction

	function automatic item_t table_item(input pos_t idx, input angle_t l, input angle_t w);
		item_t it;
		it.op          = OP_TABLE;
		it.button      = 3'($urandom);
		it.pressed     = 1'($urandom);
		it.now_time    = $urandom;
		it.entry_index = idx;
		it.entry_laser = l;
		it.entry_wind  = w;
		return it;
	endfunction

	// mostly events that fit the current mode, some table loads and noise
	function automatic item_t shaped_item();
		item_t it;
		int pick;
		usec_clock = usec_clock + usec_t'($urandom_range(0, 5000));
		it = step_item(3'($urandom_range(BTN_SPARE_LO, BTN_SPARE_HI)), 1'($urandom), usec_clock);
		pick = $urandom_range(1, 100);
		if (pick <= 8)
			return table_item(4'($urandom), 9'($urandom), 9'($urandom));
		if (pick <= 22) begin
			it.button   = 3'($urandom);
			it.pressed  = 1'($urandom);
			it.now_time = $urandom;
			return it;
		end
		case (sh_mode)
		M_IDLE: begin
			pick = $urandom_range(1, 100);
			it.pressed = 1'b1;
			if (pick <= 35)
				it.button = BTN_INC;
			else if (pick <= 70)
				it.button = BTN_DEC;
			else if (pick <= 85)
				it.button = BTN_SHOOT;
			else
				it.button = BTN_CONFIG;
		end
		M_INC: begin
			it.button  = BTN_INC;
			it.pressed = 1'b0;
		end
		M_DEC: begin
			it.button  = BTN_DEC;
			it.pressed = 1'b0;
		end
		M_ASSEMBLY: begin
			if ($urandom_range(0, 2) == 0) begin
				it.button  = BTN_NORMAL;
				it.pressed = 1'b1;
			end
		end
		M_SHOOT: begin
			if ($urandom_range(0, 3) == 0)
				it.now_time = $urandom;
		end
		M_REARM: begin
			if ($urandom_range(0, 3) != 0)
				it.now_time = sh_shot + cfg_sh.timeout + 1 + usec_t'($urandom_range(0, 1000));
			else
				it.now_time = sh_shot + usec_t'($urandom_range(0, cfg_sh.timeout));
		end
		default: ;
		endcase
		return it;
	endfunction

	task automatic send_item(input item_t it);
		if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
			step_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		step_bus.valid       <= 1'b1;
		step_bus.op          <= it.op;
		step_bus.button      <= it.button;
		step_bus.pressed     <= it.pressed;
		step_bus.now_time    <= it.now_time;
		step_bus.entry_index <= it.entry_index;
		step_bus.entry_laser <= it.entry_laser;
		step_bus.entry_wind  <= it.entry_wind;
		@(posedge clk);
		while (!step_bus.ready) @(posedge clk);
		pose_due.push_back(advance_sequencer(it));
	endtask

	task automatic settle();
		step_bus.valid <= 1'b0;
		while (pose_due.size() != 0) @(posedge clk);
	endtask

	task automatic load_settings(input cfg_t c);
		logic [31:0] word;
		settle();
		for (int r = int'(REG_LOCK_CLOSED); r <= int'(REG_POSITIONS); r++) begin
			word = $urandom;
			case (reg_idx_t'(r))
			REG_LOCK_CLOSED: begin
				word[8:0] = c.lock_closed;
				cfg_sh.lock_closed = sat_angle(c.lock_closed);
			end
			REG_LOCK_OPEN: begin
				word[8:0] = c.lock_open;
				cfg_sh.lock_open = sat_angle(c.lock_open);
			end
			REG_WIND_HOME: begin
				word[8:0] = c.wind_home;
				cfg_sh.wind_home = sat_angle(c.wind_home);
			end
			REG_LASER_ASM: begin
				word[8:0] = c.laser_asm;
				cfg_sh.laser_asm = sat_angle(c.laser_asm);
			end
			REG_TIMEOUT: begin
				word = c.timeout;
				cfg_sh.timeout = c.timeout;
			end
			default: begin
				word[4:0] = c.positions_used;
				cfg_sh.positions_used = c.positions_used;
			end
			endcase
			cfg_bus.valid <= 1'b1;
			cfg_bus.index <= reg_idx_t'(r);
			cfg_bus.data  <= word;
			@(posedge clk);
			while (!cfg_bus.ready) @(posedge clk);
		end
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic run_until(input mode_t target);
		int guard;
		guard = 0;
		while (sh_mode != target && guard < 2000) begin
			send_item(shaped_item());
			guard++;
		end
	endtask

	task automatic test_table_fill();
		for (int i = 0; i < DEPTH; i++)
			send_item(table_item(4'(i), (i == 1) ? 9'h1FF : 9'(i * 24),
				(i == 14) ? 9'd361 : 9'(360 - i * 24)));
	endtask

	task automatic test_mode_walk();
		usec_t t;
		t = usec_clock;
		send_item(step_item(BTN_SPARE_HI, 1'b1, t));
		send_item(step_item(BTN_SPARE_LO, 1'b1, t));
		send_item(step_item(BTN_INC, 1'b0, t));
		send_item(step_item(BTN_INC, 1'b1, t));
		send_item(step_item(BTN_DEC, 1'b1, t));
		send_item(step_item(BTN_INC, 1'b0, t));
		send_item(step_item(BTN_DEC, 1'b1, t));
		send_item(step_item(BTN_DEC, 1'b0, t));
		send_item(step_item(BTN_DEC, 1'b1, t));
		send_item(step_item(BTN_DEC, 1'b0, t));
		send_item(step_item(BTN_CONFIG, 1'b1, t));
		send_item(step_item(BTN_SHOOT, 1'b1, t));
		send_item(step_item(BTN_NORMAL, 1'b1, t));
		send_item(step_item(BTN_SPARE_LO, 1'b0, t));
		send_item(step_item(BTN_SHOOT, 1'b1, t));
		send_item(step_item(BTN_SPARE_LO, 1'b0, t));
		run_until(M_REARM);
		send_item(step_item(BTN_SPARE_LO, 1'b0, t + cfg_sh.timeout));
		send_item(step_item(BTN_SPARE_LO, 1'b0, t + cfg_sh.timeout + 1));
	endtask

	task automatic test_stale_index();
		cfg_t c;
		c = cfg_sh;
		c.positions_used = 5'd5;
		load_settings(c);
		run_until(M_IDLE);
		repeat (5) begin
			send_item(step_item(BTN_INC, 1'b1, usec_clock));
			send_item(step_item(BTN_INC, 1'b0, usec_clock));
		end
		c.positions_used = 5'd2;
		load_settings(c);
		repeat (3) begin
			send_item(step_item(BTN_DEC, 1'b1, usec_clock));
			send_item(step_item(BTN_DEC, 1'b0, usec_clock));
		end
		c.positions_used = 5'd0;
		load_settings(c);
		send_item(step_item(BTN_INC, 1'b1, usec_clock));
		send_item(step_item(BTN_INC, 1'b0, usec_clock));
		send_item(step_item(BTN_DEC, 1'b1, usec_clock));
		send_item(step_item(BTN_DEC, 1'b0, usec_clock));
		send_item(step_item(BTN_CONFIG, 1'b1, usec_clock));
		send_item(step_item(BTN_NORMAL, 1'b1, usec_clock));
		send_item(step_item(BTN_SPARE_HI, 1'b0, usec_clock));
	endtask

	task automatic test_rearm_wrap();
		cfg_t c;
		c = cfg_sh;
		c.lock_closed    = 9'h1FF;
		c.lock_open      = 9'd0;
		c.wind_home      = 9'h1FF;
		c.laser_asm      = 9'd0;
		c.timeout        = 32'd500;
		c.positions_used = 5'd31;
		load_settings(c);
		run_until(M_IDLE);
		send_item(step_item(BTN_SHOOT, 1'b1, usec_clock));
		send_item(step_item(BTN_SPARE_LO, 1'b0, 32'hFFFF_FF00));
		run_until(M_REARM);
		// elapsed across the wrap is exactly the timeout: hold
		send_item(step_item(BTN_SPARE_LO, 1'b0, 32'h0000_00F4));
		c.timeout = '1;
		load_settings(c);
		send_item(step_item(BTN_SPARE_LO, 1'b1, $urandom));
		c.timeout = '0;
		load_settings(c);
		send_item(step_item(BTN_SPARE_LO, 1'b0, 32'hFFFF_FF00));
		send_item(step_item(BTN_SPARE_LO, 1'b0, 32'hFFFF_FF01));
	endtask

	function automatic angle_t pick_angle();
		case ($urandom_range(0, 3))
		0: return 9'd0;
		1: return ANGLE_MAX;
		2: return 9'($urandom_range(361, 511));
		default: return 9'($urandom_range(0, 360));
		endcase
	endfunction

	task automatic test_random_phases();
		cfg_t c;
		for (int ph = 0; ph < 10; ph++) begin
			c.lock_closed = pick_angle();
			c.lock_open   = pick_angle();
			c.wind_home   = pick_angle();
			c.laser_asm   = pick_angle();
			case ($urandom_range(0, 3))
			0: c.timeout = '0;
			1: c.timeout = usec_t'($urandom_range(0, 5000));
			2: c.timeout = 32'd1000000;
			default: c.timeout = $urandom;
			endcase
			c.positions_used = (ph == 0) ? 5'd16 : 5'($urandom_range(0, 31));
			load_settings(c);
			idle_pct = (ph == 4 || ph == 9) ? 0 : $urandom_range(10, 40);
			for (int n = 0; n < 40; n++)
				send_item(shaped_item());
		end
	endtask

	function automatic void flag_pose(input string what, input pose_t want, input pose_t got);
		mismatches++;
		if (mismatches <= 10)
			$display({"%s: want mode %0d pos %0d lock %0d wind %0d laser %0d,",
				" got mode %0d pos %0d lock %0d wind %0d laser %0d"},
				what, want.mode, want.pos, want.lock, want.wind, want.laser,
				got.mode, got.pos, got.lock, got.wind, got.laser);
	endfunction

	always @(posedge clk) begin
		pose_t got;
		pose_t want;
		if (pose_bus.valid && pose_bus.ready) begin
			got = '{pose_bus.mode_code, pose_bus.position, pose_bus.lock_out,
				pose_bus.wind_out, pose_bus.laser_out};
			if (pose_due.size() == 0) begin
				flag_pose("unexpected beat", '0, got);
			end else begin
				want = pose_due.pop_front();
				if (got !== want)
					flag_pose("pose mismatch", want, got);
			end
		end
	end

	initial begin
		pose_bus.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct / 2) begin
				pose_bus.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
			pose_bus.ready <= 1'b1;
		end
	end

	initial begin
		arst_n               <= 1'b0;
		step_bus.valid       <= 1'b0;
		step_bus.op          <= OP_STEP;
		step_bus.button      <= '0;
		step_bus.pressed     <= 1'b0;
		step_bus.now_time    <= '0;
		step_bus.entry_index <= '0;
		step_bus.entry_laser <= '0;
		step_bus.entry_wind  <= '0;
		cfg_bus.valid        <= 1'b0;
		cfg_bus.index        <= REG_LOCK_CLOSED;
		cfg_bus.data         <= '0;
		mismatches = 0;
		idle_pct   = 0;
		usec_clock = $urandom;
		cfg_sh = '{9'd0, 9'd180, 9'd180, 9'd180, 32'd1000000, 5'd16};
		sh_mode  = M_RESET;
		sh_pos   = '0;
		sh_lock  = '0;
		sh_wind  = '0;
		sh_laser = '0;
		sh_shot  = '0;
		for (int i = 0; i < DEPTH; i++) begin
			laser_tab[i] = '0;
			wind_tab[i]  = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		idle_pct = 25;
		test_table_fill();
		test_mode_walk();
		test_stale_index();
		test_rearm_wrap();
		test_random_phases();
		settle();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pose_due.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/sls_pkg.sv
rtl/core/sls_if.sv
rtl/core/sls_ram.sv
rtl/core/sls_ctrl.sv
rtl/core/servo_launch_sequencer.sv
dv/tb_servo_launch_sequencer.sv
